[hdl/dwfr_pkg.sv]
`timescale 1ns / 1ps

package dwfr_pkg;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_FIND_REPL  = 3'd4;
	localparam logic [2:0] OP_SIZE       = 3'd5;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_WAIT,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
		logic signed [31:0] new_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		status_t            status;
		logic [6:0]         count;
	} rsp_t;

endpackage

[hdl/dwfr_ram.sv]
`timescale 1ns / 1ps

module dwfr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/deque_with_find_replace_unit.sv]
`timescale 1ns / 1ps

// bounded double-ended queue held in a ring memory
// req channel: one beat per operation (push front/back, pop front/back,
//   find-replace, size); rsp channel: exactly one beat per request, in order,
//   carrying the popped word, a status code and the entry count after the op
// push, size and unused codes: response registered straight from the request
//   beat; the unit stays idle, so the next request is taken once the response register can drain
// pop: the ring memory read is registered, so a pop from a non-empty queue
//   passes through ST_POP_WAIT, which loads the read word into the response
// find-replace: one memory read per cycle walking front to back; the first
//   matching entry read ends the scan and is answered, a miss over n entries
//   answers after the last one is compared; requests are held off meanwhile
// requests are taken only while the response register is empty or being
//   drained in the same cycle; a stalled response holds its beat unchanged
// reset: queue empty, front slot zero, no response pending; memory contents
//   are not cleared and are only read after being written

module deque_with_find_replace_unit #(
	parameter int DEPTH      = 64,
	parameter int WORD_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dwfr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dwfr_pkg::rsp_t rsp
);

	import dwfr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;
	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] rd_idx_q, rd_idx_d;
	logic cmp_valid_s1, cmp_valid_d;
	logic [AW-1:0] slot_s1;
	logic [WORD_WIDTH-1:0] key_q, repl_q;
	logic rsp_valid_q, rsp_load;
	rsp_t rsp_q, rsp_d;

	logic mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [WORD_WIDTH-1:0] mem_wdata, mem_rdata;

	logic accept, empty, full, match, more;
	logic [AW-1:0] front_m1, front_p1, back_slot, tail_slot, scan_slot;
	logic [CW-1:0] count_m1, count_p1;
	logic [WORD_WIDTH-1:0] in_word, in_repl;
	logic [31:0] pop_word;
	logic [WORD_WIDTH+31:0] in_word_ext, in_repl_ext, pop_ext;

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
			input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	dwfr_ram #(
		.DEPTH(DEPTH),
		.WIDTH(WORD_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign count_m1  = count_q - 1'b1;
	assign count_p1  = count_q + 1'b1;
	assign front_m1  = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign front_p1  = ring_add(front_q, AW'(1));
	assign back_slot = ring_add(front_q, count_m1[AW-1:0]);
	assign tail_slot = ring_add(front_q, count_q[AW-1:0]);
	assign scan_slot = ring_add(front_q, rd_idx_q[AW-1:0]);

	assign in_word_ext = {{WORD_WIDTH{req.value[31]}}, req.value};
	assign in_repl_ext = {{WORD_WIDTH{req.new_value[31]}}, req.new_value};
	assign in_word     = in_word_ext[WORD_WIDTH-1:0];
	assign in_repl     = in_repl_ext[WORD_WIDTH-1:0];
	assign pop_ext     = {32'b0, mem_rdata};
	assign pop_word    = pop_ext[31:0];

	assign match = cmp_valid_s1 && (mem_rdata == key_q);
	assign more  = (rd_idx_q < count_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((req.op == OP_POP_FRONT || req.op == OP_POP_BACK) && !empty) begin
						state_d = ST_POP_WAIT;
					end else if (req.op == OP_FIND_REPL) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_POP_WAIT: state_d = ST_IDLE;
			ST_SCAN: begin
				if (match || !more) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		front_d     = front_q;
		count_d     = count_q;
		rd_idx_d    = rd_idx_q;
		cmp_valid_d = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = front_m1;
		mem_wdata   = in_word;
		mem_re      = 1'b0;
		mem_raddr   = front_q;
		rsp_load    = 1'b0;
		rsp_d       = '{result_value: '0, status: STAT_OK, count: 7'(count_q)};
		unique case (state_q)
			ST_IDLE: begin
				rd_idx_d = '0;
				if (accept) begin
					unique case (req.op)
						OP_PUSH_FRONT: begin
							rsp_load = 1'b1;
							if (full) begin
								rsp_d.status = STAT_FULL;
							end else begin
								mem_we        = 1'b1;
								mem_waddr     = front_m1;
								front_d       = front_m1;
								count_d       = count_p1;
								rsp_d.count   = 7'(count_p1);
							end
						end
						OP_PUSH_BACK: begin
							rsp_load = 1'b1;
							if (full) begin
								rsp_d.status = STAT_FULL;
							end else begin
								mem_we        = 1'b1;
								mem_waddr     = tail_slot;
								count_d       = count_p1;
								rsp_d.count   = 7'(count_p1);
							end
						end
						OP_POP_FRONT: begin
							if (empty) begin
								rsp_load     = 1'b1;
								rsp_d.status = STAT_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = front_q;
								front_d   = front_p1;
								count_d   = count_m1;
							end
						end
						OP_POP_BACK: begin
							if (empty) begin
								rsp_load     = 1'b1;
								rsp_d.status = STAT_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = back_slot;
								count_d   = count_m1;
							end
						end
						OP_FIND_REPL: begin
							rd_idx_d = '0;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			ST_POP_WAIT: begin
				rsp_load           = 1'b1;
				rsp_d.result_value = pop_word;
			end
			ST_SCAN: begin
				if (match) begin
					mem_we    = 1'b1;
					mem_waddr = slot_s1;
					mem_wdata = repl_q;
					rsp_load  = 1'b1;
				end else if (more) begin
					mem_re      = 1'b1;
					mem_raddr   = scan_slot;
					rd_idx_d    = rd_idx_q + 1'b1;
					cmp_valid_d = 1'b1;
				end else begin
					rsp_load     = 1'b1;
					rsp_d.status = STAT_NOT_FOUND;
				end
			end
			default: begin
				rd_idx_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			front_q      <= '0;
			count_q      <= '0;
			rd_idx_q     <= '0;
			cmp_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			front_q      <= front_d;
			count_q      <= count_d;
			rd_idx_q     <= rd_idx_d;
			cmp_valid_s1 <= cmp_valid_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		if (accept) begin
			key_q  <= in_word;
			repl_q <= in_repl;
		end
		slot_s1 <= mem_raddr;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hdl/dwfr_checker.sv]
`timescale 1ns / 1ps

module dwfr_checker #(
	parameter int DEPTH = 64
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input dwfr_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input dwfr_pkg::rsp_t rsp
);

	import dwfr_pkg::*;

	// stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// empty pop reports an empty queue and no data
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_EMPTY |-> rsp.result_value == 0 && rsp.count == 0)
		else $error("empty pop with data or nonzero count");

	// dropped push only when full
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_FULL |-> rsp.count == 7'(DEPTH))
		else $error("full status below capacity");

	// nothing popped on a failed search
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_NOT_FOUND |-> rsp.result_value == 0)
		else $error("not-found response carries data");

endmodule

bind deque_with_find_replace_unit dwfr_checker #(
	.DEPTH(DEPTH)
) u_dwfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
